// File: rtl/signalling_link_test_supervisor_core_assert.svh
// assertion macros used by the checker file
`ifndef SIGNALLING_LINK_TEST_SUPERVISOR_CORE_ASSERT_SVH
`define SIGNALLING_LINK_TEST_SUPERVISOR_CORE_ASSERT_SVH

// same-cycle implication
`define SLTSUP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SLTSUP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/sltsup_pkg.sv
// ----------------------------------------------------------------------------
// sltsup_pkg
// types and constants of the signalling link test supervisor
// ----------------------------------------------------------------------------
package sltsup_pkg;

   localparam int MAX_LINKS_DEF  = 16;
   localparam int TIMER_BITS_DEF = 16;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LINK_COUNT    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRY_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RESET_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_TESTS     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LABELS_PRESET = 3'd4;

   localparam logic [4:0]  LINK_COUNT_RST  = 5'd1;
   localparam logic [15:0] RETRY_LIMIT_RST = 16'd100;
   localparam logic [15:0] RESET_LIMIT_RST = 16'd1000;
   localparam logic [3:0]  MAX_TESTS_RST   = 4'd2;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_RESUME  = 3'd1,
      CMD_PAUSE   = 3'd2,
      CMD_ACK     = 3'd3,
      CMD_TEST_RX = 3'd4,
      CMD_SELECT  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_SEND_TEST  = 3'd0,
      KIND_RESET_LINK = 3'd1,
      KIND_ASSOC_UP   = 3'd2,
      KIND_ASSOC_DOWN = 3'd3,
      KIND_SEND_ACK   = 3'd4,
      KIND_SELECTED   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_ENTRY,
      ST_COUNT,
      ST_MOD,
      ST_SEARCH,
      ST_SEL2,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [3:0] link_index;
      logic [3:0] sls;
   } req_item_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] link_out;
      logic [4:0] live_links;
      logic       last;
   } rsp_item_type;

endpackage

// File: rtl/signalling_link_test_supervisor_core.sv
// ----------------------------------------------------------------------------
// signalling_link_test_supervisor_core
// per-link test supervisor: link timers and test counts in one memory
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_item (cmd, link_index, sls)
//   rsp      out  rsp_valid/rsp_ready    rsp_item (kind, link_out, live_links, last)
//   csr      in   csr_we                 csr_index, csr_wdata
//
// tick: one memory read-modify-write per link, plus output stalls
// resume, ack received, test received: one memory read-modify-write; ack and pause add a
// live link recount over the link_up flags
// select: up to 16/n reduction steps then up to n search steps
// reset clears the memory valid flags at once, no clearing pass
// a full output register stalls the walk only when a second result is due
// ----------------------------------------------------------------------------
module signalling_link_test_supervisor_core
   import sltsup_pkg::*;
#(
   parameter int MAX_LINKS  = MAX_LINKS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_item,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int IW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int CW = $clog2(MAX_LINKS + 1);
   localparam int W  = (CW > 5) ? CW : 5;
   localparam int TW = TIMER_BITS;
   localparam int LW = (TW > 16) ? TW : 16;
   localparam int EW = 2 * TW + 5;

   // configuration
   logic [4:0]  link_count_ff;
   logic [15:0] retry_limit_ff;
   logic [15:0] reset_limit_ff;
   logic [3:0]  max_tests_ff;
   logic        labels_preset_ff;

   // link entry memory: label, pending tests, short timer, long timer
   logic [EW-1:0]        mem [MAX_LINKS];
   logic [MAX_LINKS-1:0] vld_ff;
   logic [EW-1:0]        rdata_ff;
   logic                 rvld_ff;
   logic                 mem_rd_en;
   logic [IW-1:0]        mem_raddr;
   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   logic [EW-1:0]        mem_wdata;

   state_type            state_ff, state_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic [3:0]           li_ff, li_in;
   logic [W-1:0]         s_ff, s_in;
   logic [W-1:0]         u0_ff, u0_in;
   logic [W-1:0]         idx_ff, idx_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        up_count_ff, up_count_in;
   logic [MAX_LINKS-1:0] link_up_ff, link_up_in;
   logic                 hold_v_ff, hold_v_in;
   kind_type             hold_kind_ff, hold_kind_in;
   logic [3:0]           hold_link_ff, hold_link_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_ff, rsp_in;

   logic [W-1:0]  n_eff, n_last, lc_w;
   logic [IW-1:0] laddr;
   logic          out_free;
   logic          push, push_last;

   // entry decode and tick update
   logic [EW-1:0] ent;
   logic          e_lab;
   logic [3:0]    e_pend, t_pend;
   logic [TW-1:0] e_sh, e_lg, t_sh, t_lg;
   logic          t_send, t_rst, t_emit;
   logic [CW-1:0] cnt_sum;

   always_comb begin
      lc_w = W'(link_count_ff);
      if (lc_w == '0) begin
         n_eff = W'(1);
      end else if (lc_w > W'(MAX_LINKS)) begin
         n_eff = W'(MAX_LINKS);
      end else begin
         n_eff = lc_w;
      end
      n_last = n_eff - W'(1);
   end

   assign laddr    = IW'(li_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign ent    = rvld_ff ? rdata_ff : '0;
   assign e_lab  = ent[EW-1];
   assign e_pend = ent[EW-2 -: 4];
   assign e_sh   = ent[2*TW-1:TW];
   assign e_lg   = ent[TW-1:0];

   // tick step for the entry in the read register
   always_comb begin
      logic [TW-1:0] sh1, lg1;
      sh1    = (e_sh == '1) ? e_sh : e_sh + TW'(1);
      lg1    = (e_lg == '1) ? e_lg : e_lg + TW'(1);
      t_send = (LW'(sh1) > LW'(retry_limit_ff)) && (e_pend != '0) &&
               (e_pend < max_tests_ff);
      t_pend = t_send ? e_pend + 4'd1 : e_pend;
      t_sh   = t_send ? '0 : sh1;
      t_lg   = t_send ? '0 : lg1;
      t_rst  = (LW'(t_lg) > LW'(reset_limit_ff)) && (t_pend >= max_tests_ff);
      if (t_rst) begin
         t_pend = '0;
         t_sh   = '0;
         t_lg   = '0;
      end
      t_emit = (t_send && (e_lab || labels_preset_ff)) || t_rst;
   end

   assign cnt_sum = cnt_ff + CW'(link_up_ff[idx_ff[IW-1:0]]);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      li_in        = li_ff;
      s_in         = s_ff;
      u0_in        = u0_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      up_count_in  = up_count_ff;
      link_up_in   = link_up_ff;
      hold_v_in    = hold_v_ff;
      hold_kind_in = hold_kind_ff;
      hold_link_in = hold_link_ff;
      mem_rd_en    = 1'b0;
      mem_raddr    = '0;
      mem_we       = 1'b0;
      mem_waddr    = laddr;
      mem_wdata    = ent;
      push         = 1'b0;
      push_last    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_item.cmd;
               li_in  = req_item.link_index;
               s_in   = W'(req_item.sls);
               idx_in = '0;
               cnt_in = '0;
               if (req_item.cmd == CMD_TICK) begin
                  mem_rd_en = 1'b1;
                  mem_raddr = '0;
                  state_in  = ST_TICK;
               end else if (req_item.cmd == CMD_SELECT) begin
                  state_in = ST_MOD;
               end else if ((req_item.cmd == CMD_RESUME || req_item.cmd == CMD_PAUSE ||
                             req_item.cmd == CMD_ACK || req_item.cmd == CMD_TEST_RX) &&
                            (W'(req_item.link_index) < n_eff)) begin
                  if (req_item.cmd == CMD_PAUSE) begin
                     link_up_in[IW'(req_item.link_index)] = 1'b0;
                     state_in = ST_COUNT;
                  end else begin
                     mem_rd_en = 1'b1;
                     mem_raddr = IW'(req_item.link_index);
                     state_in  = ST_ENTRY;
                  end
               end
            end
         end

         ST_TICK: begin
            // a second result needs the held one moved out first
            if (!(t_emit && hold_v_ff && !out_free)) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff[IW-1:0];
               mem_wdata = {e_lab, t_pend, t_sh, t_lg};
               if (t_emit) begin
                  push         = hold_v_ff;
                  hold_v_in    = 1'b1;
                  hold_kind_in = t_rst ? KIND_RESET_LINK : KIND_SEND_TEST;
                  hold_link_in = 4'(idx_ff);
               end
               if (idx_ff == n_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in    = idx_ff + W'(1);
                  mem_rd_en = 1'b1;
                  mem_raddr = IW'(idx_ff + W'(1));
               end
            end
         end

         ST_ENTRY: begin
            mem_we       = 1'b1;
            hold_v_in    = 1'b1;
            hold_link_in = li_ff;
            state_in     = ST_FLUSH;
            if (cmd_ff == CMD_RESUME) begin
               mem_wdata    = {e_lab, (e_pend == 4'hF) ? e_pend : e_pend + 4'd1,
                               {TW{1'b0}}, {TW{1'b0}}};
               hold_kind_in = KIND_SEND_TEST;
            end else if (cmd_ff == CMD_ACK) begin
               mem_wdata         = {e_lab, 4'd0, e_sh, e_lg};
               link_up_in[laddr] = 1'b1;
               hold_v_in         = (up_count_ff == '0);
               hold_kind_in      = KIND_ASSOC_UP;
               state_in          = ST_COUNT;
            end else begin
               mem_wdata    = {1'b1, e_pend, e_sh, e_lg};
               hold_kind_in = KIND_SEND_ACK;
            end
         end

         ST_COUNT: begin
            if (idx_ff == n_last) begin
               up_count_in = cnt_sum;
               if (cmd_ff == CMD_PAUSE && cnt_sum == '0) begin
                  hold_v_in    = 1'b1;
                  hold_kind_in = KIND_ASSOC_DOWN;
                  hold_link_in = li_ff;
               end
               state_in = ST_FLUSH;
            end else begin
               cnt_in = cnt_sum;
               idx_in = idx_ff + W'(1);
            end
         end

         ST_MOD: begin
            // sls mod n by repeated subtraction
            if (s_ff >= n_eff) begin
               s_in = s_ff - n_eff;
            end else begin
               u0_in    = s_ff;
               idx_in   = '0;
               state_in = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            if (link_up_ff[s_ff[IW-1:0]]) begin
               hold_v_in    = 1'b1;
               hold_kind_in = KIND_SELECTED;
               hold_link_in = 4'(s_ff);
               state_in     = ST_FLUSH;
            end else if (idx_ff == n_last) begin
               up_count_in  = '0;
               hold_v_in    = 1'b1;
               hold_kind_in = KIND_ASSOC_DOWN;
               hold_link_in = 4'(u0_ff);
               state_in     = ST_SEL2;
            end else begin
               idx_in = idx_ff + W'(1);
               s_in   = (s_ff == n_last) ? '0 : s_ff + W'(1);
            end
         end

         ST_SEL2: begin
            if (out_free) begin
               push         = 1'b1;
               hold_kind_in = KIND_SELECTED;
               hold_link_in = 4'(u0_ff);
               state_in     = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            if (!hold_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               hold_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (push) begin
         rsp_valid_in       = 1'b1;
         rsp_in.kind        = hold_kind_ff;
         rsp_in.link_out    = hold_link_ff;
         rsp_in.live_links  = 5'(up_count_ff);
         rsp_in.last        = push_last;
      end
   end

   // memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_rd_en) begin
         rdata_ff <= mem[mem_raddr];
         rvld_ff  <= vld_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_count_ff    <= LINK_COUNT_RST;
         retry_limit_ff   <= RETRY_LIMIT_RST;
         reset_limit_ff   <= RESET_LIMIT_RST;
         max_tests_ff     <= MAX_TESTS_RST;
         labels_preset_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINK_COUNT:    link_count_ff    <= csr_wdata[4:0];
            CSR_RETRY_LIMIT:   retry_limit_ff   <= csr_wdata;
            CSR_RESET_LIMIT:   reset_limit_ff   <= csr_wdata;
            CSR_MAX_TESTS:     max_tests_ff     <= csr_wdata[3:0];
            CSR_LABELS_PRESET: labels_preset_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         up_count_ff  <= '0;
         link_up_ff   <= '0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         up_count_ff  <= up_count_in;
         link_up_ff   <= link_up_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      li_ff        <= li_in;
      s_ff         <= s_in;
      u0_ff        <= u0_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      hold_kind_ff <= hold_kind_in;
      hold_link_ff <= hold_link_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// File: rtl/sltsup_checker.sv
// ----------------------------------------------------------------------------
// sltsup_checker
// port-level checks of the signalling link test supervisor
// ----------------------------------------------------------------------------
`include "signalling_link_test_supervisor_core_assert.svh"

module sltsup_checker
   import sltsup_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   // stalled result holds
   `SLTSUP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

   // the selected link always closes its item
   `SLTSUP_ASSERT_IMPL(a_sel_last, clock, reset, rsp_valid && rsp_item.kind == KIND_SELECTED, rsp_item.last)

   // association down is only reported with no live link
   `SLTSUP_ASSERT_IMPL(a_down_zero, clock, reset, rsp_valid && rsp_item.kind == KIND_ASSOC_DOWN, rsp_item.live_links == 5'd0)

   // a tick keeps the block busy for its walk
   `SLTSUP_ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && req_ready && req_item.cmd == CMD_TICK, !req_ready)

endmodule

bind signalling_link_test_supervisor_core sltsup_checker u_sltsup_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// File: verif/signalling_link_test_supervisor_core_tb.sv
// ----------------------------------------------------------------------------
// signalling_link_test_supervisor_core_tb
// self-checking bench: a directed table of link events at reset settings, then
// phases of random events, each under its own register settings, with random
// idling on both channels but in quiet phases; each result is compared with
// its table row or with a link supervisor model kept inside the bench
// ----------------------------------------------------------------------------
module signalling_link_test_supervisor_core_tb;
   import sltsup_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int         SETTLE       = 64;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_item_type             req_item;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_item_type             rsp_item;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   signalling_link_test_supervisor_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model of the linkset
   logic [4:0]  cfg_links;
   logic [15:0] cfg_retry;
   logic [15:0] cfg_reset;
   logic [3:0]  cfg_tests;
   logic        cfg_preset;
   logic        lk_up      [16];
   logic [3:0]  lk_pending [16];
   logic [15:0] lk_short   [16];
   logic [15:0] lk_long    [16];
   logic        lk_label   [16];
   logic [4:0]  live_count;

   rsp_item_type step_results[$];
   rsp_item_type pending_results[$];

   typedef struct {
      req_item_type req;
      bit           typed;
      bit           has_rsp;
      rsp_item_type rsp;
   } dir_row_type;
   dir_row_type dir_rows[$];

   int  errors = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   bit  quiet = 0;
   bit  started = 0;

   function automatic int served_links();
      if (cfg_links == 0) return 1;
      if (cfg_links > 16) return 16;
      return cfg_links;
   endfunction

   function automatic void recount_live(int n);
      int c;
      c = 0;
      for (int i = 0; i < n; i++) if (lk_up[i]) c++;
      live_count = c[4:0];
   endfunction

   function automatic void add_result(kind_type k, int lnk);
      rsp_item_type r;
      r = '0;
      r.kind = k;
      r.link_out = lnk[3:0];
      step_results.push_back(r);
   endfunction

   // works out the results of one event and updates the linkset
   function automatic void supervise_event(req_item_type it);
      int n, li, u;
      bit found;
      n = served_links();
      li = it.link_index;
      step_results.delete();
      if (it.cmd >= CMD_RESUME && it.cmd <= CMD_TEST_RX && li >= n) return;
      case (it.cmd)
         CMD_TICK: begin
            for (int i = 0; i < n; i++) begin
               if (lk_long[i] != 16'hFFFF) lk_long[i]++;
               if (lk_short[i] != 16'hFFFF) lk_short[i]++;
               if (lk_short[i] > cfg_retry && lk_pending[i] != 0 &&
                   lk_pending[i] < cfg_tests) begin
                  lk_pending[i]++;
                  lk_long[i] = 0;
                  lk_short[i] = 0;
                  if (lk_label[i] || cfg_preset) add_result(KIND_SEND_TEST, i);
               end
               if (lk_long[i] > cfg_reset && lk_pending[i] >= cfg_tests) begin
                  lk_long[i] = 0;
                  lk_short[i] = 0;
                  lk_pending[i] = 0;
                  add_result(KIND_RESET_LINK, i);
               end
            end
         end
         CMD_RESUME: begin
            if (lk_pending[li] != 4'hF) lk_pending[li]++;
            lk_long[li] = 0;
            lk_short[li] = 0;
            add_result(KIND_SEND_TEST, li);
         end
         CMD_PAUSE: begin
            lk_up[li] = 0;
            recount_live(n);
            if (live_count == 0) add_result(KIND_ASSOC_DOWN, li);
         end
         CMD_ACK: begin
            lk_pending[li] = 0;
            lk_up[li] = 1;
            if (live_count == 0) add_result(KIND_ASSOC_UP, li);
            recount_live(n);
         end
         CMD_TEST_RX: begin
            lk_label[li] = 1;
            add_result(KIND_SEND_ACK, li);
         end
         CMD_SELECT: begin
            u = it.sls % n;
            found = lk_up[u];
            for (int i = 0; i < n && !found; i++)
               if (lk_up[(it.sls + i) % n]) begin
                  u = (it.sls + i) % n;
                  found = 1;
               end
            if (!found) begin
               u = it.sls % n;
               live_count = 0;
               add_result(KIND_ASSOC_DOWN, u);
            end
            add_result(KIND_SELECTED, u);
         end
         default: ;
      endcase
      foreach (step_results[j]) begin
         step_results[j].live_links = live_count;
         step_results[j].last = (j == step_results.size() - 1);
      end
   endfunction

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      case (idx)
         CSR_LINK_COUNT:  cfg_links = value[4:0];
         CSR_RETRY_LIMIT: cfg_retry = value[15:0];
         CSR_RESET_LIMIT: cfg_reset = value[15:0];
         CSR_MAX_TESTS:   cfg_tests = value[3:0];
         default:         cfg_preset = value[0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      // nothing more is offered while waiting
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(int lc, int rl, int sl, int mt, int lp);
      wait_drained();
      write_reg(CSR_LINK_COUNT, lc);
      write_reg(CSR_RETRY_LIMIT, rl);
      write_reg(CSR_RESET_LIMIT, sl);
      write_reg(CSR_MAX_TESTS, mt);
      write_reg(CSR_LABELS_PRESET, lp);
   endtask

   // offers one event, returns once it has been taken
   task automatic offer_event(req_item_type it, bit typed, bit has_rsp,
                              rsp_item_type rsp);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      supervise_event(it);
      if (typed) begin
         if (has_rsp) pending_results.push_back(rsp);
      end else begin
         foreach (step_results[j]) pending_results.push_back(step_results[j]);
      end
   endtask

   function automatic req_item_type random_event();
      req_item_type it;
      int r, n;
      n = served_links();
      r = $urandom_range(0, 99);
      if (r < 40)      it.cmd = CMD_TICK;
      else if (r < 52) it.cmd = CMD_RESUME;
      else if (r < 62) it.cmd = CMD_ACK;
      else if (r < 72) it.cmd = CMD_PAUSE;
      else if (r < 80) it.cmd = CMD_TEST_RX;
      else if (r < 95) it.cmd = CMD_SELECT;
      else             it.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      it.link_index = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, n - 1);
      it.sls = $urandom_range(0, 15);
      return it;
   endfunction

   function automatic void add_row(logic [2:0] cmd, int lnk, int sls, bit typed,
                                   bit has_rsp, kind_type k, int live);
      dir_row_type d;
      d.req.cmd = cmd;
      d.req.link_index = lnk[3:0];
      d.req.sls = sls[3:0];
      d.typed = typed;
      d.has_rsp = has_rsp;
      d.rsp.kind = k;
      d.rsp.link_out = lnk[3:0];
      d.rsp.live_links = live[4:0];
      d.rsp.last = 1'b1;
      dir_rows.push_back(d);
   endfunction

   // result side
   initial begin
      int stall;
      rsp_item_type e;
      rsp_ready = 1'b0;
      wait (started);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 17);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result kind=%0d link_out=%0d", rsp_item.kind,
                   rsp_item.link_out);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_item.kind !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_item.kind);
               errors++;
            end
            if (rsp_item.link_out !== e.link_out) begin
               $error("link_out: expected %0d, got %0d", e.link_out, rsp_item.link_out);
               errors++;
            end
            if (rsp_item.live_links !== e.live_links) begin
               $error("live_links: expected %0d, got %0d", e.live_links,
                      rsp_item.live_links);
               errors++;
            end
            if (rsp_item.last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_item.last);
               errors++;
            end
         end
      end
   end

   // event side
   initial begin
      rsp_item_type none;
      int lc, rl, sl, mt, lp;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_links = LINK_COUNT_RST;
      cfg_retry = RETRY_LIMIT_RST;
      cfg_reset = RESET_LIMIT_RST;
      cfg_tests = MAX_TESTS_RST;
      cfg_preset = 1'b0;
      for (int i = 0; i < 16; i++) begin
         lk_up[i] = 0; lk_pending[i] = 0; lk_short[i] = 0;
         lk_long[i] = 0; lk_label[i] = 0;
      end
      live_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      started = 1;

      // one link served after reset
      add_row(CMD_SELECT,   0, 15, 0, 0, KIND_SELECTED,   0);
      add_row(CMD_TEST_RX,  0, 0,  1, 1, KIND_SEND_ACK,   0);
      add_row(CMD_RESUME,   0, 0,  1, 1, KIND_SEND_TEST,  0);
      add_row(CMD_TICK,     0, 0,  0, 0, KIND_SEND_TEST,  0);
      add_row(CMD_ACK,      0, 0,  1, 1, KIND_ASSOC_UP,   1);
      add_row(CMD_SELECT,   0, 0,  0, 0, KIND_SELECTED,   0);
      add_row(CMD_SELECT,   0, 15, 0, 0, KIND_SELECTED,   0);
      add_row(CMD_PAUSE,    0, 0,  1, 1, KIND_ASSOC_DOWN, 0);
      add_row(CMD_PAUSE,    0, 0,  1, 1, KIND_ASSOC_DOWN, 0);
      add_row(CMD_RESUME,   15, 0, 1, 0, KIND_SEND_TEST,  0);
      add_row(CMD_ACK,      3, 0,  1, 0, KIND_SEND_TEST,  0);
      add_row(CMD_TEST_RX,  15, 0, 1, 0, KIND_SEND_TEST,  0);
      add_row(CMD_PAUSE,    9, 0,  1, 0, KIND_SEND_TEST,  0);
      add_row(CMD_SPARE_LO, 0, 0,  1, 0, KIND_SEND_TEST,  0);
      add_row(CMD_SPARE_HI, 15, 15, 1, 0, KIND_SEND_TEST, 0);
      add_row(CMD_RESUME,   0, 0,  0, 0, KIND_SEND_TEST,  0);
      add_row(CMD_TICK,     0, 0,  0, 0, KIND_SEND_TEST,  0);
      foreach (dir_rows[i])
         offer_event(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has_rsp,
                     dir_rows[i].rsp);

      for (int p = 0; p < 9; p++) begin
         case (p)
            0: begin lc = 16; rl = 0;     sl = 0;     mt = 0;  lp = 1; end
            1: begin lc = 31; rl = 65535; sl = 65535; mt = 15; lp = 0; end
            2: begin lc = 0;  rl = 2;     sl = 5;     mt = 3;  lp = 1; end
            3: begin lc = 4;  rl = 1;     sl = 3;     mt = 2;  lp = 0; end
            default: begin
               lc = $urandom_range(0, 31); rl = $urandom_range(0, 4);
               sl = $urandom_range(0, 8);  mt = $urandom_range(0, 5);
               lp = $urandom_range(0, 1);
            end
         endcase
         configure(lc, rl, sl, mt, lp);
         quiet = (p % 3 == 1);
         for (int k = 0; k < 54; k++) begin
            // hold back until the block has caught up
            if (k == 27) wait_drained();
            offer_event(random_event(), 0, 0, none);
         end
         quiet = 0;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      $display("run covered %0d events and %0d results over 10 register settings",
               items_sent, results_seen);
      if (errors == 0)
         $display("** signalling_link_test_supervisor_core: PASSED **");
      else
         $display("** signalling_link_test_supervisor_core: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("** signalling_link_test_supervisor_core: FAILED **");
      $finish;
   end

endmodule
